### rtl/core/mtp_pkg.sv
// ----------------------------------------------------------------------------
// mtp_pkg
// shared constants and command types for the mt19937 generator
// ----------------------------------------------------------------------------
package mtp_pkg;

  localparam int STATE_WORDS  = 624;
  localparam int TWIST_OFFSET = 397;
  localparam int ADDR_W       = $clog2(STATE_WORDS);

  typedef logic [31:0]       word_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam addr_t LAST_ADDR = addr_t'(STATE_WORDS - 1);

  localparam word_t INIT_MULT    = 32'h6c07_8965;
  localparam word_t TWIST_MATRIX = 32'h9908_b0df;
  localparam word_t TEMPER_B     = 32'h9d2c_5680;
  localparam word_t TEMPER_C     = 32'hefc6_0000;
  localparam word_t UPPER_MASK   = 32'h8000_0000;
  localparam word_t LOWER_MASK   = 32'h7fff_ffff;

  typedef enum logic {
    CMD_DRAW = 1'b0,
    CMD_SEED = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    word_t     seed;
  } cmd_t;

endpackage

### rtl/core/mtp_if.sv
// ----------------------------------------------------------------------------
// mtp_if
// valid/ready channels of the generator: request channel and result channel
// ----------------------------------------------------------------------------
interface mtp_in_if;
  logic              valid;
  logic              ready;
  logic              func;
  mtp_pkg::word_t    seed;

  modport source (output valid, output func, output seed, input ready);
  modport sink   (input valid, input func, input seed, output ready);
endinterface

interface mtp_out_if;
  logic              valid;
  logic              ready;
  mtp_pkg::word_t    random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

### rtl/core/mtp_front.sv
// ----------------------------------------------------------------------------
// mtp_front
// accepts requests, classifies them as draw or seed and queues them
// ----------------------------------------------------------------------------
module mtp_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           hold,
  mtp_in_if.sink         in_ch,
  output logic           cmd_valid,
  input  logic           cmd_ready,
  output mtp_pkg::cmd_t  cmd
);

  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  mtp_pkg::cmd_t    queue_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  mtp_pkg::cmd_t    in_cmd;
  logic             push, pop;

  // classify the incoming item
  always_comb begin
    in_cmd.kind = in_ch.func ? mtp_pkg::CMD_SEED : mtp_pkg::CMD_DRAW;
    in_cmd.seed = in_ch.seed;
  end

  assign in_ch.ready = (count_r != CNT_W'(QUEUE_DEPTH)) && !hold;
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (count_r != '0);
  assign pop         = cmd_valid && cmd_ready;
  assign cmd         = queue_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

### rtl/core/mtp_back.sv
// ----------------------------------------------------------------------------
// mtp_back
// state memory and sequencer: clear pass, seeding, lazy twist and tempering
// ----------------------------------------------------------------------------
module mtp_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  mtp_pkg::cmd_t  cmd,
  output logic           clr_busy,
  mtp_out_if.source      out_ch
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEED,
    ST_RD1,
    ST_WB
  } state_t;

  localparam int SUM_W = mtp_pkg::ADDR_W + 1;

  state_t          state_r;
  mtp_pkg::addr_t  idx_r;
  mtp_pkg::addr_t  pos_r;
  logic            live_r;
  mtp_pkg::word_t  prev_r;
  mtp_pkg::word_t  wk_r;
  logic            out_valid_r;
  mtp_pkg::word_t  out_word_r;

  mtp_pkg::word_t  words_r [mtp_pkg::STATE_WORDS];
  mtp_pkg::word_t  q0_r, q1_r;

  logic            mem_we;
  mtp_pkg::addr_t  mem_wa;
  mtp_pkg::word_t  mem_wd;
  logic            rd0_en, rd1_en;
  mtp_pkg::addr_t  rd0_a, rd1_a;

  mtp_pkg::addr_t  pos_inc;
  logic [SUM_W-1:0] far_sum;
  mtp_pkg::addr_t  far_a;
  mtp_pkg::word_t  seed_nxt;
  mtp_pkg::word_t  twist_v;
  mtp_pkg::word_t  draw_word;
  logic            do_twist;
  logic            wb_go;
  logic            out_load;

  function automatic mtp_pkg::word_t temper(input mtp_pkg::word_t w);
    mtp_pkg::word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & mtp_pkg::TEMPER_B);
    y = y ^ ((y << 15) & mtp_pkg::TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic mtp_pkg::word_t twist(input mtp_pkg::word_t cur,
                                           input mtp_pkg::word_t nxt,
                                           input mtp_pkg::word_t far);
    mtp_pkg::word_t y;
    mtp_pkg::word_t v;
    y = (cur & mtp_pkg::UPPER_MASK) | (nxt & mtp_pkg::LOWER_MASK);
    v = far ^ (y >> 1);
    if (y[0]) begin
      v = v ^ mtp_pkg::TWIST_MATRIX;
    end
    return v;
  endfunction

  // address arithmetic, all modulo the state size
  assign pos_inc = (pos_r == mtp_pkg::LAST_ADDR) ? '0 : pos_r + mtp_pkg::ADDR_W'(1);
  assign far_sum = {1'b0, pos_r} + SUM_W'(mtp_pkg::TWIST_OFFSET);
  assign far_a   = (far_sum >= SUM_W'(mtp_pkg::STATE_WORDS))
                 ? mtp_pkg::ADDR_W'(far_sum - SUM_W'(mtp_pkg::STATE_WORDS))
                 : mtp_pkg::ADDR_W'(far_sum);

  // init recurrence step
  assign seed_nxt = (mtp_pkg::INIT_MULT * (prev_r ^ (prev_r >> 30)))
                  + mtp_pkg::word_t'(idx_r);

  // a word is regenerated at its draw inside a twist round
  assign do_twist  = (pos_r == '0) || live_r;
  assign twist_v   = twist(wk_r, q1_r, q0_r);
  assign draw_word = do_twist ? twist_v : wk_r;
  assign wb_go     = !out_valid_r || out_ch.ready;
  assign out_load  = (state_r == ST_WB) && wb_go;

  assign cmd_ready          = (state_r == ST_IDLE);
  assign clr_busy           = (state_r == ST_CLEAR);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.random_word = out_word_r;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    rd0_en = 1'b0;
    rd1_en = 1'b0;
    rd0_a  = pos_r;
    rd1_a  = pos_inc;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = idx_r;
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.kind == mtp_pkg::CMD_SEED) begin
            mem_we = 1'b1;
            mem_wd = cmd.seed;
          end else begin
            rd0_en = 1'b1;
            rd1_en = 1'b1;
          end
        end
      end
      ST_SEED: begin
        mem_we = 1'b1;
        mem_wa = idx_r;
        mem_wd = seed_nxt;
      end
      ST_RD1: begin
        rd0_en = 1'b1;
        rd0_a  = far_a;
      end
      ST_WB: begin
        if (wb_go && do_twist) begin
          mem_we = 1'b1;
          mem_wa = pos_r;
          mem_wd = twist_v;
        end
      end
      default: begin
      end
    endcase
  end

  // state memory: one write, two registered reads
  always_ff @(posedge clk) begin
    if (mem_we) begin
      words_r[mem_wa] <= mem_wd;
    end
    if (rd0_en) begin
      q0_r <= words_r[rd0_a];
    end
    if (rd1_en) begin
      q1_r <= words_r[rd1_a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      pos_r       <= '0;
      live_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // result register empties on transfer unless a new word lands
      if (out_valid_r && out_ch.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          if (idx_r == mtp_pkg::LAST_ADDR) begin
            idx_r   <= '0;
            state_r <= ST_IDLE;
          end else begin
            idx_r <= idx_r + mtp_pkg::ADDR_W'(1);
          end
        end
        ST_IDLE: begin
          if (cmd_valid) begin
            if (cmd.kind == mtp_pkg::CMD_SEED) begin
              prev_r  <= cmd.seed;
              idx_r   <= mtp_pkg::ADDR_W'(1);
              live_r  <= 1'b0;
              state_r <= ST_SEED;
            end else begin
              state_r <= ST_RD1;
            end
          end
        end
        ST_SEED: begin
          prev_r <= seed_nxt;
          if (idx_r == mtp_pkg::LAST_ADDR) begin
            idx_r   <= '0;
            state_r <= ST_IDLE;
          end else begin
            idx_r <= idx_r + mtp_pkg::ADDR_W'(1);
          end
        end
        ST_RD1: begin
          wk_r    <= q0_r;
          state_r <= ST_WB;
        end
        ST_WB: begin
          if (wb_go) begin
            out_valid_r <= 1'b1;
            out_word_r  <= temper(draw_word);
            pos_r       <= pos_inc;
            live_r      <= do_twist;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= mtp_pkg::LAST_ADDR)
    else $error("read position out of range");

  a_pos_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB && wb_go && pos_r == mtp_pkg::LAST_ADDR) |=> (pos_r == '0))
    else $error("read position did not wrap");

  a_seed_ends_round: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && cmd_valid && cmd.kind == mtp_pkg::CMD_SEED)
      |=> (state_r == ST_SEED && !live_r))
    else $error("seed did not end the twist round");

  a_draw_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WB && wb_go) |=> out_valid_r)
    else $error("draw finished without a result");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (!out_valid_r && !cmd_ready))
    else $error("activity during clear pass");
`endif

endmodule

### rtl/core/mersenne_twister_prng.sv
// ----------------------------------------------------------------------------
// mersenne_twister_prng
// mt19937 generator with a 624-word state memory and lazy per-word twist
// ----------------------------------------------------------------------------
// usage
//   in_ch  : request channel, func = 0 draws one word, func = 1 seeds with seed
//   out_ch : result channel, one tempered random_word per draw, none per seed
//   both channels transfer when valid and ready are high at a rising clk edge
// timing
//   a draw steps through ST_IDLE, ST_RD1 and ST_WB in the back end (reads of
//   current and next words, then the offset word, then twist and write back
//   where due, and temper); the result is registered, so it appears the cycle
//   after the last step; a seed writes the seed to word 0, then one state word
//   per cycle through the multiply-add of the init recurrence
//   a two-entry request queue lets the front take transfers while the back
//   is busy
// reset
//   rst_n starts a clear pass that zeroes all 624 words of the state memory;
//   in_ch.ready stays low until it ends; read position restarts at 0
// stall
//   while out_ch.ready is low the result holds and the back end waits with
//   the next draw; the queue fills and then in_ch.ready drops
// ----------------------------------------------------------------------------
module mersenne_twister_prng (
  input  logic        clk,
  input  logic        rst_n,
  mtp_in_if.sink      in_ch,
  mtp_out_if.source   out_ch
);

  // front to back command handoff
  logic           cmd_valid;
  logic           cmd_ready;
  mtp_pkg::cmd_t  cmd;

  // high during the post-reset clear pass
  logic           clr_busy;

  // request intake and classification
  mtp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .hold      (clr_busy),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // state memory, seeding, twist and tempering
  mtp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .clr_busy  (clr_busy),
    .out_ch    (out_ch)
  );

endmodule
